// ===== design/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked at every rising clock edge outside reset
`define ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ===== design/efp_pkg.sv =====
package efp_pkg;

   localparam int PIX_W      = 11;
   localparam int Q_W        = 32;
   localparam int Q_FRAC     = 28;
   localparam int PAN_W      = 21;
   localparam int STEP_W     = 31;
   localparam int ITER_W     = 8;
   localparam int CNT_W      = ITER_W + 1;
   localparam int PITCH_W    = 15;
   localparam int COLOR_W    = 24;
   localparam int OFS_OUT_W  = 25;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam int WIDE_W     = 64;

   localparam int FRAME_HEIGHT_DEF    = 1024;
   localparam int BYTES_PER_PIXEL_DEF = 4;

   localparam logic [COLOR_W-1:0] COLOR_LOW  = 24'hABCDEF;
   localparam logic [COLOR_W-1:0] COLOR_HIGH = 24'hFEDCBA;
   localparam int SPAN_W    = 23;
   localparam logic [SPAN_W-1:0] COLOR_SPAN = SPAN_W'(COLOR_HIGH - COLOR_LOW);
   localparam int PROD_W    = SPAN_W + ITER_W;
   localparam int DIV_STEPS = PROD_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   localparam logic signed [WIDE_W-1:0] Q_TWO        = 64'sd536870912;
   localparam logic signed [WIDE_W-1:0] Q_MAX_WIDE   = 64'sd2147483647;
   localparam logic signed [WIDE_W-1:0] Q_MIN_WIDE   = -64'sd2147483648;
   localparam logic        [WIDE_W-1:0] ESCAPE_BOUND = 64'h0400_0000_0000_0000;

   localparam logic [STEP_W-1:0]  STEP_RST  = 31'h0010_0000;
   localparam logic [ITER_W-1:0]  ITER_RST  = 8'd50;
   localparam logic [PITCH_W-1:0] PITCH_RST = 15'd4096;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MODE,
      CSR_JULIA_RE,
      CSR_JULIA_IM,
      CSR_PAN_H,
      CSR_PAN_V,
      CSR_STEP,
      CSR_MAX_ITER,
      CSR_PITCH
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAP,
      ST_SEED,
      ST_MUL,
      ST_UPD,
      ST_CMUL,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                      julia;
      logic signed [Q_W-1:0]     c_re;
      logic signed [Q_W-1:0]     c_im;
      logic signed [PAN_W-1:0]   pan_h;
      logic signed [PAN_W-1:0]   pan_v;
      logic        [STEP_W-1:0]  step;
      logic        [ITER_W-1:0]  max_iter;
      logic        [PITCH_W-1:0] pitch;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic map;
      logic seed;
      logic mul;
      logic step;
      logic finish;
      logic cmul;
      logic div;
   } cmd_type;

   typedef struct packed {
      logic escaped;
      logic at_limit;
      logic div_last;
   } sts_type;

   function automatic logic signed [Q_W-1:0] sat_q(input logic signed [WIDE_W-1:0] v);
      logic signed [Q_W-1:0] r;
      if (v > Q_MAX_WIDE) begin
         r = Q_W'(Q_MAX_WIDE);
      end else if (v < Q_MIN_WIDE) begin
         r = Q_W'(Q_MIN_WIDE);
      end else begin
         r = Q_W'(v);
      end
      return r;
   endfunction

endpackage

// ===== design/efp_csr.sv =====
module efp_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [efp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [efp_pkg::CSR_DATA_W-1:0] csr_wdata,
   output efp_pkg::cfg_type               cfg
);
   import efp_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_MODE:     cfg_in.julia    = csr_wdata[0];
            CSR_JULIA_RE: cfg_in.c_re     = $signed(csr_wdata[Q_W-1:0]);
            CSR_JULIA_IM: cfg_in.c_im     = $signed(csr_wdata[Q_W-1:0]);
            CSR_PAN_H:    cfg_in.pan_h    = $signed(csr_wdata[PAN_W-1:0]);
            CSR_PAN_V:    cfg_in.pan_v    = $signed(csr_wdata[PAN_W-1:0]);
            CSR_STEP:     cfg_in.step     = csr_wdata[STEP_W-1:0];
            CSR_MAX_ITER: cfg_in.max_iter = csr_wdata[ITER_W-1:0];
            CSR_PITCH:    cfg_in.pitch    = csr_wdata[PITCH_W-1:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.julia    <= 1'b0;
         cfg_ff.c_re     <= '0;
         cfg_ff.c_im     <= '0;
         cfg_ff.pan_h    <= '0;
         cfg_ff.pan_v    <= '0;
         cfg_ff.step     <= STEP_RST;
         cfg_ff.max_iter <= ITER_RST;
         cfg_ff.pitch    <= PITCH_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== design/efp_ctrl.sv =====
module efp_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  efp_pkg::sts_type sts,
   output efp_pkg::cmd_type cmd,
   output logic             busy,
   output logic             done
);
   import efp_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (start) begin
            state_in = ST_MAP;
         end
         ST_MAP:  state_in = ST_SEED;
         ST_SEED: state_in = ST_MUL;
         ST_MUL:  state_in = ST_UPD;
         ST_UPD: begin
            if (sts.escaped || sts.at_limit) begin
               state_in = ST_CMUL;
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_CMUL: state_in = ST_DIV;
         ST_DIV: if (sts.div_last) begin
            state_in = ST_DONE;
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      done = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         ST_MAP:  cmd.map  = 1'b1;
         ST_SEED: cmd.seed = 1'b1;
         ST_MUL:  cmd.mul  = 1'b1;
         ST_UPD: begin
            cmd.finish = sts.escaped || sts.at_limit;
            cmd.step   = !(sts.escaped || sts.at_limit);
         end
         ST_CMUL: cmd.cmul = 1'b1;
         ST_DIV:  cmd.div  = 1'b1;
         ST_DONE: done     = 1'b1;
         default: busy     = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== design/efp_dp.sv =====
module efp_dp #(
   parameter int FRAME_HEIGHT    = efp_pkg::FRAME_HEIGHT_DEF,
   parameter int BYTES_PER_PIXEL = efp_pkg::BYTES_PER_PIXEL_DEF
) (
   input  logic                          clock,
   input  efp_pkg::cmd_type              cmd,
   input  efp_pkg::cfg_type              cfg,
   input  logic [efp_pkg::PIX_W-1:0]     pixel_x,
   input  logic [efp_pkg::PIX_W-1:0]     pixel_y,
   output efp_pkg::sts_type              sts,
   output logic [efp_pkg::CNT_W-1:0]     iteration_count,
   output logic [efp_pkg::COLOR_W-1:0]   pixel_color,
   output logic [efp_pkg::OFS_OUT_W-1:0] buffer_offset,
   output logic                          write_enable
);
   import efp_pkg::*;

   localparam int PX_W   = PAN_W + 1;
   localparam int MAP_W  = PX_W + Q_W;
   localparam int PY_W   = PITCH_W + PIX_W;
   localparam int XB_W   = PIX_W + $clog2(BYTES_PER_PIXEL + 1);
   localparam int OFS_W  = ((PY_W > XB_W) ? PY_W : XB_W) + 1;
   localparam int BND_W  = PITCH_W + $clog2(FRAME_HEIGHT + 1);
   localparam int CMP_W  = (OFS_W > BND_W) ? OFS_W : BND_W;
   localparam logic [CMP_W-1:0] OFS_SPAN = CMP_W'(1) << OFS_OUT_W;

   logic [PIX_W-1:0]               x_ff, x_in, y_ff, y_in;
   logic signed [MAP_W-1:0]        mre_ff, mre_in, mim_ff, mim_in;
   logic [PY_W-1:0]                pyp_ff, pyp_in;
   logic signed [Q_W-1:0]          zr_ff, zr_in, zi_ff, zi_in;
   logic signed [Q_W-1:0]          cr_ff, cr_in, ci_ff, ci_in;
   logic signed [WIDE_W-1:0]       rr_ff, rr_in, ii_ff, ii_in, ri_ff, ri_in;
   logic [ITER_W-1:0]              it_ff, it_in;
   logic [CNT_W-1:0]               cnt_ff, cnt_in;
   logic [OFS_OUT_W-1:0]           ofs_ff, ofs_in;
   logic                           we_ff, we_in;
   logic [PROD_W-1:0]              dvd_ff, dvd_in;
   logic [ITER_W-1:0]              rem_ff, rem_in;
   logic [DIV_CNT_W-1:0]           dcnt_ff, dcnt_in;

   logic signed [PX_W-1:0]         px, py;
   logic signed [Q_W-1:0]          step_s, p_re, p_im;
   logic [WIDE_W-1:0]              mag;
   logic signed [WIDE_W-1:0]       nr_sum, ni_sum;
   logic [OFS_W-1:0]               ofs;
   logic [CMP_W-1:0]               ofs_x, bnd_x;
   logic                           in_bounds;
   logic [ITER_W:0]                trial, divisor;
   logic                           ge;
   logic [ITER_W-1:0]              cnt_less;

   always_comb begin
      px     = $signed({{(PX_W-PIX_W){1'b0}}, x_ff}) + PX_W'(cfg.pan_h);
      py     = $signed({{(PX_W-PIX_W){1'b0}}, y_ff}) + PX_W'(cfg.pan_v);
      step_s = $signed({1'b0, cfg.step});
      p_re   = sat_q(WIDE_W'(mre_ff) - Q_TWO);
      p_im   = sat_q(Q_TWO - WIDE_W'(mim_ff));

      ofs       = OFS_W'(pyp_ff) + OFS_W'(XB_W'(x_ff) * XB_W'(BYTES_PER_PIXEL));
      ofs_x     = CMP_W'(ofs);
      bnd_x     = CMP_W'(BND_W'(cfg.pitch) * BND_W'(FRAME_HEIGHT));
      in_bounds = (ofs_x < bnd_x) && (ofs_x < OFS_SPAN);

      mag    = rr_ff + ii_ff;
      nr_sum = (rr_ff >>> Q_FRAC) - (ii_ff >>> Q_FRAC) + WIDE_W'(cr_ff);
      ni_sum = (ri_ff >>> (Q_FRAC - 1)) + WIDE_W'(ci_ff);

      sts.escaped  = (it_ff != '0) && (mag > ESCAPE_BOUND);
      sts.at_limit = (it_ff == cfg.max_iter);
      sts.div_last = (dcnt_ff == DIV_CNT_W'(DIV_STEPS - 1));

      cnt_less = ITER_W'(cnt_ff - CNT_W'(1));
      trial    = {rem_ff, dvd_ff[PROD_W-1]};
      divisor  = {1'b0, cfg.max_iter};
      ge       = (trial >= divisor);
   end

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      mre_in  = mre_ff;
      mim_in  = mim_ff;
      pyp_in  = pyp_ff;
      zr_in   = zr_ff;
      zi_in   = zi_ff;
      cr_in   = cr_ff;
      ci_in   = ci_ff;
      rr_in   = rr_ff;
      ii_in   = ii_ff;
      ri_in   = ri_ff;
      it_in   = it_ff;
      cnt_in  = cnt_ff;
      ofs_in  = ofs_ff;
      we_in   = we_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dcnt_in = dcnt_ff;
      if (cmd.load) begin
         x_in = pixel_x;
         y_in = pixel_y;
      end
      if (cmd.map) begin
         mre_in = px * step_s;
         mim_in = py * step_s;
         pyp_in = PY_W'(cfg.pitch) * PY_W'(y_ff);
      end
      if (cmd.seed) begin
         zr_in  = cfg.julia ? p_re : '0;
         zi_in  = cfg.julia ? p_im : '0;
         cr_in  = cfg.julia ? cfg.c_re : p_re;
         ci_in  = cfg.julia ? cfg.c_im : p_im;
         it_in  = '0;
         we_in  = in_bounds;
         ofs_in = in_bounds ? OFS_OUT_W'(ofs) : '0;
      end
      if (cmd.mul) begin
         rr_in = zr_ff * zr_ff;
         ii_in = zi_ff * zi_ff;
         ri_in = zr_ff * zi_ff;
      end
      if (cmd.step) begin
         zr_in = sat_q(nr_sum);
         zi_in = sat_q(ni_sum);
         it_in = it_ff + ITER_W'(1);
      end
      if (cmd.finish) begin
         cnt_in = sts.escaped ? CNT_W'(it_ff) : CNT_W'(it_ff) + CNT_W'(1);
      end
      if (cmd.cmul) begin
         dvd_in  = PROD_W'(COLOR_SPAN) * PROD_W'(cnt_less);
         rem_in  = '0;
         dcnt_in = '0;
      end
      if (cmd.div) begin
         rem_in  = ge ? ITER_W'(trial - divisor) : ITER_W'(trial);
         dvd_in  = {dvd_ff[PROD_W-2:0], ge};
         dcnt_in = dcnt_ff + DIV_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      mre_ff  <= mre_in;
      mim_ff  <= mim_in;
      pyp_ff  <= pyp_in;
      zr_ff   <= zr_in;
      zi_ff   <= zi_in;
      cr_ff   <= cr_in;
      ci_ff   <= ci_in;
      rr_ff   <= rr_in;
      ii_ff   <= ii_in;
      ri_ff   <= ri_in;
      it_ff   <= it_in;
      cnt_ff  <= cnt_in;
      ofs_ff  <= ofs_in;
      we_ff   <= we_in;
      dvd_ff  <= dvd_in;
      rem_ff  <= rem_in;
      dcnt_ff <= dcnt_in;
   end

   assign iteration_count = cnt_ff;
   assign pixel_color     = (cfg.max_iter == '0) ? COLOR_LOW
                                                 : COLOR_W'(dvd_ff) + COLOR_LOW;
   assign buffer_offset   = ofs_ff;
   assign write_enable    = we_ff;

endmodule

// ===== design/escape_time_fractal_pixel.sv =====
// Escape-time fractal pixel engine, one pixel at a time. A pixel is taken when start is
// high while busy is low; busy then stays high until the result has been shown. The
// result appears on the rsp_ ports for exactly one cycle with rsp_valid high and cannot
// be held off, so the receiver must take it in that cycle. After the accepting edge the
// block runs through coordinate mapping (ST_MAP, ST_SEED), then one pass of the z-squared
// unit per iteration (three parallel products in ST_MUL, then add, saturate and escape test
// in ST_UPD), the color product (ST_CMUL), a bit-serial divide for the color (ST_DIV) and
// the result state (ST_DONE). The iteration limit resets to 50 and can be set up to 255.
// The user must write registers on the csr_ port only while busy is low; the block itself
// does not enforce this.
`include "assert_macros.svh"

module escape_time_fractal_pixel #(
   parameter int FRAME_HEIGHT    = efp_pkg::FRAME_HEIGHT_DEF,
   parameter int BYTES_PER_PIXEL = efp_pkg::BYTES_PER_PIXEL_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [efp_pkg::PIX_W-1:0]      req_pixel_x,
   input  logic [efp_pkg::PIX_W-1:0]      req_pixel_y,
   output logic                           rsp_valid,
   output logic [efp_pkg::CNT_W-1:0]      rsp_iteration_count,
   output logic [efp_pkg::COLOR_W-1:0]    rsp_pixel_color,
   output logic [efp_pkg::OFS_OUT_W-1:0]  rsp_buffer_offset,
   output logic                           rsp_write_enable,
   input  logic                           csr_we,
   input  logic [efp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [efp_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import efp_pkg::*;

   cfg_type cfg;
   cmd_type cmd;
   sts_type sts;
   logic    count_ok;

   efp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   efp_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .sts   (sts),
      .cmd   (cmd),
      .busy  (busy),
      .done  (rsp_valid)
   );

   efp_dp #(
      .FRAME_HEIGHT    (FRAME_HEIGHT),
      .BYTES_PER_PIXEL (BYTES_PER_PIXEL)
   ) u_dp (
      .clock           (clock),
      .cmd             (cmd),
      .cfg             (cfg),
      .pixel_x         (req_pixel_x),
      .pixel_y         (req_pixel_y),
      .sts             (sts),
      .iteration_count (rsp_iteration_count),
      .pixel_color     (rsp_pixel_color),
      .buffer_offset   (rsp_buffer_offset),
      .write_enable    (rsp_write_enable)
   );

   assign count_ok = (rsp_iteration_count != '0) &&
                     (rsp_iteration_count <= CNT_W'(cfg.max_iter) + CNT_W'(1));

   `ASSERT_IMP(a_rsp_while_busy, clock, reset, rsp_valid, busy)
   `ASSERT_NXT(a_accept_sets_busy, clock, reset, start && !busy, busy && !rsp_valid)
   `ASSERT_NXT(a_single_strobe, clock, reset, rsp_valid, !rsp_valid && !busy)
   `ASSERT_IMP(a_offset_cleared, clock, reset, rsp_valid && !rsp_write_enable, ~|rsp_buffer_offset)
   `ASSERT_IMP(a_count_range, clock, reset, rsp_valid, count_ok)

endmodule
